// File: rtl/core/rbca_pkg.sv
// shared types for the region bound and cell align block
`default_nettype none

package rbca_pkg;

  // status of the shared remainder unit, seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rbca_div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rbca_if.sv
// request and result channel interfaces for the region bound and cell align block
`default_nettype none

interface rbca_req_if #(
  parameter int COORD_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] region_low;
  logic [COORD_WIDTH-1:0] region_high;
  logic [COORD_WIDTH-1:0] grid_size;
  logic [COORD_WIDTH-1:0] bound_low;
  logic [COORD_WIDTH-1:0] bound_high;
  logic                   last_dim;

  modport source (
    output valid, region_low, region_high, grid_size, bound_low, bound_high, last_dim,
    input  ready
  );
  modport sink (
    input  valid, region_low, region_high, grid_size, bound_low, bound_high, last_dim,
    output ready
  );
endinterface

interface rbca_rsp_if #(
  parameter int COORD_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] new_low;
  logic [COORD_WIDTH-1:0] new_high;
  logic [COORD_WIDTH-2:0] new_cell;
  logic                   dim_changed;
  logic                   region_changed;
  logic                   last_out;

  modport source (
    output valid, new_low, new_high, new_cell, dim_changed, region_changed, last_out,
    input  ready
  );
  modport sink (
    input  valid, new_low, new_high, new_cell, dim_changed, region_changed, last_out,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/rbca_rem_unit.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module rbca_rem_unit import rbca_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output rbca_div_stat_t   stat,
  output logic [WIDTH-1:0] rem
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dsr;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;

  logic [WIDTH-1:0] rem_sh;
  logic [WIDTH:0]   trial;

  // shift in the next dividend bit and try a subtract
  // the partial remainder stays below the divisor, which is below half range
  assign rem_sh = {rem[WIDTH-2:0], dvd[WIDTH-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dsr};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CntW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      rem <= trial[WIDTH] ? rem_sh : trial[WIDTH-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: rtl/core/region_bound_and_cell_align_core.sv
// Region bound and cell align core: takes one dimension of a view region per request, clamps
// low and high into the global bounds with a single shared comparator (one clamp a cycle),
// forces a non-positive cell size to 1, trims the span to a whole number of cells with a
// bit-serial remainder unit (one bit a cycle), and fixes inverted edges. One request is in
// work at a time; the result sits in an output register, so the next request can be taken
// while it waits. region_changed ORs the change flags of the region so far and clears after
// last_dim.
`default_nettype none

module region_bound_and_cell_align_core import rbca_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  rbca_req_if.sink  req,
  rbca_rsp_if.source rsp
);

  localparam logic [COORD_WIDTH-1:0] Sign = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] One  = COORD_WIDTH'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LO_UP,
    S_LO_DN,
    S_HI_DN,
    S_HI_UP,
    S_SPAN,
    S_DIV,
    S_FIX
  } state_t;

  state_t state;

  // working registers, coordinates held as order-preserving unsigned keys
  logic [COORD_WIDTH-1:0] lo;
  logic [COORD_WIDTH-1:0] hi;
  logic [COORD_WIDTH-1:0] grid;
  logic [COORD_WIDTH-1:0] glb;
  logic [COORD_WIDTH-1:0] gub;
  logic                   item_last;
  logic                   chg;
  logic                   changed_so_far;

  // result register
  logic                   out_valid;
  logic [COORD_WIDTH-1:0] out_low;
  logic [COORD_WIDTH-1:0] out_high;
  logic [COORD_WIDTH-2:0] out_cell;
  logic                   out_dim;
  logic                   out_region;
  logic                   out_last;

  // shared comparator
  logic [COORD_WIDTH-1:0] cmp_a;
  logic [COORD_WIDTH-1:0] cmp_b;
  logic                   lt;

  // remainder unit
  logic                   div_start;
  rbca_div_stat_t         div_stat;
  logic [COORD_WIDTH-1:0] div_rem;

  logic                   grid_bad;
  logic                   region_next;
  logic                   out_free;
  logic                   load_out;

  // operand select for the one comparator
  always_comb begin
    case (state)
      S_LO_UP: begin cmp_a = lo;  cmp_b = glb; end
      S_LO_DN: begin cmp_a = gub; cmp_b = lo;  end
      S_HI_DN: begin cmp_a = gub; cmp_b = hi;  end
      S_HI_UP: begin cmp_a = hi;  cmp_b = glb; end
      S_SPAN:  begin cmp_a = lo;  cmp_b = hi;  end
      S_FIX:   begin cmp_a = hi;  cmp_b = lo;  end
      default: begin cmp_a = lo;  cmp_b = hi;  end
    endcase
  end

  assign lt          = cmp_a < cmp_b;
  assign grid_bad    = (grid == '0) || grid[COORD_WIDTH-1];
  assign div_start   = (state == S_SPAN) && lt;
  assign region_next = changed_so_far | chg | lt;
  assign out_free    = !out_valid || rsp.ready;
  assign load_out    = (state == S_FIX) && out_free;

  rbca_rem_unit #(
    .WIDTH (COORD_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hi - lo),
    .divisor  (grid),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  // sequencer with registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      changed_so_far <= 1'b0;
    end else begin
      // result offered until taken, reloaded when the sequencer finishes
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            lo        <= req.region_low ^ Sign;
            hi        <= req.region_high ^ Sign;
            grid      <= req.grid_size;
            glb       <= req.bound_low ^ Sign;
            gub       <= req.bound_high ^ Sign;
            item_last <= req.last_dim;
            chg       <= 1'b0;
            state     <= S_LO_UP;
          end
        end
        S_LO_UP: begin
          if (lt) begin
            lo  <= glb;
            chg <= 1'b1;
          end
          state <= S_LO_DN;
        end
        S_LO_DN: begin
          if (lt) begin
            lo  <= gub;
            chg <= 1'b1;
          end
          state <= S_HI_DN;
        end
        S_HI_DN: begin
          if (lt) begin
            hi  <= gub;
            chg <= 1'b1;
          end
          state <= S_HI_UP;
        end
        S_HI_UP: begin
          if (lt) begin
            hi <= glb;
          end
          if (grid_bad) begin
            grid <= One;
          end
          if (lt || grid_bad) begin
            chg <= 1'b1;
          end
          state <= S_SPAN;
        end
        S_SPAN: begin
          state <= lt ? S_DIV : S_FIX;
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (div_rem != '0) begin
              hi  <= hi - div_rem;
              chg <= 1'b1;
            end
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (out_free) begin
            out_low        <= lo ^ Sign;
            out_high       <= (lt ? lo : hi) ^ Sign;
            out_cell       <= grid[COORD_WIDTH-2:0];
            out_dim        <= chg | lt;
            out_region     <= region_next;
            out_last       <= item_last;
            changed_so_far <= item_last ? 1'b0 : region_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE) && !rst;
  assign rsp.valid          = out_valid;
  assign rsp.new_low        = out_low;
  assign rsp.new_high       = out_high;
  assign rsp.new_cell       = out_cell;
  assign rsp.dim_changed    = out_dim;
  assign rsp.region_changed = out_region;
  assign rsp.last_out       = out_last;

endmodule

`default_nettype wire

// File: rtl/core/rbca_checker.sv
// port-level checks for the region bound and cell align core, with its bind
`default_nettype none

module rbca_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [COORD_WIDTH-1:0] new_low,
  input logic [COORD_WIDTH-1:0] new_high,
  input logic [COORD_WIDTH-2:0] new_cell,
  input logic                   dim_changed,
  input logic                   region_changed
);

  // a stalled result stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its edges and cell size
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(new_low) && $stable(new_high) && $stable(new_cell))
    else $error("result payload changed while stalled");

  // cell size never reported as zero
  a_cell_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> new_cell != '0)
    else $error("cell size of zero reported");

  // the region flag covers the dimension flag
  a_region_covers: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && dim_changed |-> region_changed)
    else $error("region flag missing a dimension change");

  // edges come out ordered
  a_edges_ordered: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $signed(new_low) <= $signed(new_high))
    else $error("low edge above high edge");

endmodule

bind region_bound_and_cell_align_core rbca_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rbca_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .new_low        (rsp.new_low),
  .new_high       (rsp.new_high),
  .new_cell       (rsp.new_cell),
  .dim_changed    (rsp.dim_changed),
  .region_changed (rsp.region_changed)
);

`default_nettype wire
